>>> src/pmrb_pkg.sv
`default_nettype none
package pmrb_pkg;

	// physical RAM geometry
	localparam int RamAddrBits = 17;
	localparam int RamBytes = 1 << RamAddrBits;
	localparam int PageRegCount = 16;
	localparam int PageIdxBits = $clog2(PageRegCount);

	// width of an untruncated translated address: 8-bit page and 13-bit offset
	localparam int PhysFullBits = 21;

	// front-to-back queue
	localparam int QueueDepth = 2;
	localparam int QPtrBits = $clog2(QueueDepth);
	localparam int QCntBits = $clog2(QueueDepth + 1);

	// configuration port
	localparam int PAddrBits = 3;
	localparam logic CfgTaskSel = 1'b0;

	// access codes
	localparam logic OpRead = 1'b0;
	localparam logic OpWrite = 1'b1;

	// I/O window decode
	localparam logic [7:0] IoPage = 8'hFF;
	localparam logic [6:0] VecPage = 7'h7F;
	localparam logic [11:0] PageRegBase = 12'hFFA;
	localparam logic [15:0] MmuCtlAddr = 16'hFF90;
	localparam logic [14:0] AllRamAddr = 15'h7FEF;
	localparam logic [19:0] FixedBase = 20'h70000;
	localparam int MmuEnBit = 6;
	localparam int ConstVecBit = 3;

	// one translated access on its way to the RAM
	typedef struct packed {
		logic is_write;
		logic hit;
		logic [RamAddrBits-1:0] phys;
		logic [7:0] data;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage
`default_nettype wire

>>> src/paged_mmu_ram_bus.sv
`default_nettype none
// Channel  Handshake            Payload
// in       in_valid / in_stall  opcode, addr, write_data
// out      out_valid/ out_stall read_data, ram_hit
// cfg      APB psel/penable     paddr, pwdata, prdata (task_select at 0)
//
// One item per cycle sustained while out_stall is low; from accept to result
// each item passes decode into the queue, the registered RAM read, the output
// register. The single-port RAM gives one access per cycle and sets that figure.
// After reset the RAM is filled with its pattern, one byte a cycle over all
// 2^17 = 131072 bytes; in_stall stays high until the fill is done.
// A stalled output holds its item; the two-entry queue absorbs the front.
module paged_mmu_ram_bus (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic [15:0] addr,
	input wire logic [7:0] write_data,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] read_data,
	output logic ram_hit,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [pmrb_pkg::PAddrBits-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import pmrb_pkg::*;

	logic task_sel_q;
	logic accept;
	logic pop;
	logic clr_done;
	q_entry_t entry;
	q_entry_t head;
	q_status_t q_status;

	assign in_stall = q_status.full || !clr_done;
	assign accept = in_valid && !in_stall;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == CfgTaskSel) ? {31'b0, task_sel_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_sel_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == CfgTaskSel) begin
			task_sel_q <= pwdata[0];
		end
	end

	pmrb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.opcode(opcode),
		.addr(addr),
		.write_data(write_data),
		.task_sel(task_sel_q),
		.entry(entry)
	);

	pmrb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_entry(entry),
		.pop(pop),
		.head(head),
		.status(q_status)
	);

	pmrb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_status(q_status),
		.pop(pop),
		.clr_done(clr_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.ram_hit(ram_hit)
	);

`ifndef SYNTH
	// nothing enters while the RAM fill is running
	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> in_stall)
		else $error("item accepted during RAM fill");

	// queue is never popped empty nor pushed full
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty) && !(accept && q_status.full))
		else $error("queue overflow or underflow");

	// a config write lands in task_select on the next cycle
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[2] == CfgTaskSel) |=>
		(task_sel_q == $past(pwdata[0])))
		else $error("task select not updated");
`endif

endmodule
`default_nettype wire

>>> src/pmrb_queue.sv
`default_nettype none
module pmrb_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire pmrb_pkg::q_entry_t push_entry,
	input wire logic pop,
	output pmrb_pkg::q_entry_t head,
	output pmrb_pkg::q_status_t status
);
	import pmrb_pkg::*;

	q_entry_t slot_q [QueueDepth];
	logic [QPtrBits-1:0] wr_ptr_q;
	logic [QPtrBits-1:0] rd_ptr_q;
	logic [QCntBits-1:0] cnt_q;

	assign head = slot_q[rd_ptr_q];
	assign status.empty = (cnt_q == '0);
	assign status.full = (cnt_q == QCntBits'(QueueDepth));

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

>>> src/pmrb_front.sv
`default_nettype none
module pmrb_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic opcode,
	input wire logic [15:0] addr,
	input wire logic [7:0] write_data,
	input wire logic task_sel,
	output pmrb_pkg::q_entry_t entry
);
	import pmrb_pkg::*;

	logic [7:0] page_q [PageRegCount];
	logic mmu_on_q;
	logic const_vec_q;
	logic all_ram_q;

	logic is_io;
	logic is_write;
	logic use_mmu;
	logic [PageIdxBits-1:0] page_idx;
	logic [PhysFullBits-1:0] phys_full;

	// decode and translate
	always_comb begin
		is_io = (addr[15:8] == IoPage);
		is_write = (opcode == OpWrite);
		use_mmu = mmu_on_q && (!(addr[15:9] == VecPage) || !const_vec_q);
		page_idx = {task_sel, addr[15:13]};
		if (use_mmu) begin
			phys_full = {page_q[page_idx], addr[12:0]};
		end else begin
			phys_full = PhysFullBits'(FixedBase + {4'b0, addr});
		end
		entry.is_write = is_write;
		entry.hit = !is_io && (all_ram_q || !addr[15]);
		entry.phys = phys_full[RamAddrBits-1:0];
		entry.data = write_data;
	end

	// I/O window register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PageRegCount; i++) begin
				page_q[i] <= '0;
			end
			mmu_on_q <= 1'b0;
			const_vec_q <= 1'b0;
			all_ram_q <= 1'b0;
		end else if (accept && is_write && is_io) begin
			if (mmu_on_q && addr[15:4] == PageRegBase) begin
				page_q[addr[3:0]] <= write_data;
			end else if (addr == MmuCtlAddr) begin
				mmu_on_q <= write_data[MmuEnBit];
				const_vec_q <= write_data[ConstVecBit];
			end else if (addr[15:1] == AllRamAddr) begin
				all_ram_q <= addr[0];
			end
		end
	end

endmodule
`default_nettype wire

>>> src/pmrb_back.sv
`default_nettype none
module pmrb_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire pmrb_pkg::q_entry_t head,
	input wire pmrb_pkg::q_status_t q_status,
	output logic pop,
	output logic clr_done,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] read_data,
	output logic ram_hit
);
	import pmrb_pkg::*;

	logic [7:0] mem_q [RamBytes];
	logic [7:0] ram_rd_q;
	logic [RamAddrBits-1:0] clr_idx_q;
	logic clr_done_q;

	logic valid_s1;
	logic is_write_s1;
	logic hit_s1;
	logic [7:0] data_s1;

	logic out_valid_q;
	logic [7:0] read_data_q;
	logic ram_hit_q;
	logic advance;

	assign advance = !out_valid_q || !out_stall;
	assign pop = clr_done_q && !q_status.empty && (!valid_s1 || advance);
	assign clr_done = clr_done_q;
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign ram_hit = ram_hit_q;

	// pattern fill pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {RamAddrBits{1'b1}}) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// RAM: pattern fill, then one access per popped item
	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			mem_q[clr_idx_q] <= clr_idx_q[2] ? 8'h00 : 8'hFF;
		end else if (pop && head.is_write && head.hit) begin
			mem_q[head.phys] <= head.data;
		end
		if (pop) begin
			ram_rd_q <= mem_q[head.phys];
		end
	end

	// access stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// access stage and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			is_write_s1 <= head.is_write;
			hit_s1 <= head.hit;
			data_s1 <= head.data;
		end
		if (advance && valid_s1) begin
			ram_hit_q <= hit_s1;
			if (is_write_s1) begin
				read_data_q <= data_s1;
			end else begin
				read_data_q <= hit_s1 ? ram_rd_q : 8'h00;
			end
		end
	end

endmodule
`default_nettype wire

>>> tb/sv/pmrb_checker.sv
`timescale 1ns / 100ps
// Watches the bus and config channels, keeps its own copy of the paged RAM
// and MMU state, and checks every reply against the predicted one.
module pmrb_checker
	import pmrb_pkg::*;
#(
	parameter logic [PAddrBits-1:0] TaskSelAddr = '0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic opcode,
	input wire logic [15:0] addr,
	input wire logic [7:0] write_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] read_data,
	input wire logic ram_hit,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PAddrBits-1:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	output int fails,
	output int pending
);

	localparam int MaxReports = 10;

	typedef struct {
		logic [7:0] rd;
		logic hit;
	} reply_t;

	// shadow state
	logic [7:0] page_reg [PageRegCount];
	logic [7:0] ram_img [RamBytes];
	logic mmu_en;
	logic vec_fixed;
	logic ram_all;
	logic task_sel;

	reply_t expected_replies [$];

	// apply one bus access to the shadow state and return its reply
	function automatic reply_t predict_access(logic op, logic [15:0] a, logic [7:0] d);
		reply_t r;
		logic [PhysFullBits-1:0] full;
		logic [RamAddrBits-1:0] phys;
		r.rd = 8'h00;
		r.hit = 1'b0;
		if (a[15:8] == IoPage) begin
			// I/O window: only writes have an effect
			if (op == OpWrite) begin
				if (mmu_en && a[15:4] == PageRegBase) begin
					page_reg[a[3:0]] = d;
				end else if (a == MmuCtlAddr) begin
					mmu_en = d[MmuEnBit];
					vec_fixed = d[ConstVecBit];
				end else if (a[15:1] == AllRamAddr) begin
					ram_all = a[0];
				end
			end
		end else if (ram_all || !a[15]) begin
			// translate; constant vectors bypass the MMU when enabled
			if (mmu_en && (a[15:9] != VecPage || !vec_fixed)) begin
				full = {page_reg[{task_sel, a[15:13]}], a[12:0]};
			end else begin
				full = a;
				full = full + FixedBase;
			end
			phys = full[RamAddrBits-1:0];
			r.hit = 1'b1;
			if (op == OpWrite) begin
				ram_img[phys] = d;
			end else begin
				r.rd = ram_img[phys];
			end
		end
		if (op == OpWrite) begin
			r.rd = d;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		logic bad;
		if (!arst_n) begin
			for (int i = 0; i < PageRegCount; i++) begin
				page_reg[i] = 8'h00;
			end
			// four 0xFF bytes then four 0x00 bytes, repeating
			for (int i = 0; i < RamBytes; i++) begin
				ram_img[i] = (i & 4) != 0 ? 8'h00 : 8'hFF;
			end
			mmu_en = 1'b0;
			vec_fixed = 1'b0;
			ram_all = 1'b0;
			task_sel = 1'b0;
			fails = 0;
			expected_replies.delete();
			pending <= 0;
		end else begin
			// config write
			if (psel && penable && pwrite && pready && paddr == TaskSelAddr) begin
				task_sel = pwdata[0];
			end
			// accepted bus access
			if (in_valid && !in_stall) begin
				expected_replies.push_back(predict_access(opcode, addr, write_data));
			end
			// accepted reply
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					fails++;
					if (fails <= MaxReports) begin
						$display("%0t: unexpected item read_data=%h ram_hit=%b",
							$realtime, read_data, ram_hit);
					end
				end else begin
					want = expected_replies.pop_front();
					bad = 1'b0;
					if (read_data !== want.rd) bad = 1'b1;
					if (ram_hit !== want.hit) bad = 1'b1;
					if (bad) begin
						fails++;
						if (fails <= MaxReports) begin
							$display("%0t: mismatch read_data exp %h got %h, ram_hit exp %b got %b",
								$realtime, want.rd, read_data, want.hit, ram_hit);
						end
					end
				end
			end
			pending <= expected_replies.size();
		end
	end

endmodule

>>> tb/sv/tb_paged_mmu_ram_bus.sv
`timescale 1ns / 100ps
module tb_paged_mmu_ram_bus;
	import pmrb_pkg::*;

	localparam logic [PAddrBits-1:0] TaskSelAddr = {CfgTaskSel, 2'b00};
	localparam int IdleLimit = 400000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles = 500;
	localparam int PhaseItems = 270;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [15:0] addr = 16'h0000;
	logic [7:0] write_data = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] read_data;
	logic ram_hit;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PAddrBits-1:0] paddr = '0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic pready;

	int fails;
	int pending;
	int idle_cycles = 0;
	bit steady = 1'b0;
	bit hold_out = 1'b0;

	always #10 clk = ~clk;

	paged_mmu_ram_bus dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.addr(addr),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.ram_hit(ram_hit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	pmrb_checker #(.TaskSelAddr(TaskSelAddr)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.addr(addr),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.ram_hit(ram_hit),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.fails(fails),
		.pending(pending)
	);

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		else if (r < 85) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	// offer one item and hold it until accepted
	task automatic send_access(logic op, logic [15:0] a, logic [7:0] d);
		int gap;
		gap = (steady || hold_out) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		addr <= a;
		write_data <= d;
		do @(posedge clk); while (in_stall);
	endtask

	// wait until every reply is back, then let the pipeline settle
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// APB write of the task select register
	task automatic set_task_select(logic sel);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TaskSelAddr;
		pwdata <= {31'h0, sel};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// bring up the MMU with random pages, then a random mix of accesses
	task automatic run_phase(int count);
		logic [15:0] a;
		logic [7:0] d;
		logic op;
		int pick;
		logic [15:0] recent [$];
		d = 8'($urandom);
		d[MmuEnBit] = 1'b1;
		send_access(OpWrite, MmuCtlAddr, d);
		for (int i = 0; i < PageRegCount; i++) begin
			send_access(OpWrite, {PageRegBase, 4'(i)}, 8'($urandom));
		end
		send_access(OpWrite, {AllRamAddr, 1'($urandom_range(0, 3) != 0)}, 8'($urandom));
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			d = 8'($urandom);
			op = 1'($urandom);
			if (pick < 40) begin
				a = 16'($urandom_range(0, 16'hFEFF));
			end else if (pick < 60 && recent.size() > 0) begin
				a = recent[$urandom_range(0, recent.size() - 1)];
			end else if (pick < 68) begin
				a = {VecPage, 1'b0, 8'($urandom)};
			end else if (pick < 80) begin
				a = {PageRegBase, 4'($urandom)};
				op = ($urandom_range(0, 9) != 0) ? OpWrite : OpRead;
			end else if (pick < 85) begin
				a = MmuCtlAddr;
				d[MmuEnBit] = ($urandom_range(0, 4) != 0);
				op = ($urandom_range(0, 9) != 0) ? OpWrite : OpRead;
			end else if (pick < 90) begin
				a = {AllRamAddr, 1'($urandom_range(0, 2) != 0)};
				op = ($urandom_range(0, 9) != 0) ? OpWrite : OpRead;
			end else begin
				a = {IoPage, 8'($urandom)};
			end
			// remember written RAM addresses for later read-back
			if (op == OpWrite && a[15:8] != IoPage) begin
				recent.push_back(a);
				if (recent.size() > 16) void'(recent.pop_front());
			end
			send_access(op, a, d);
		end
	endtask

	// receiver: random stalls, a long hold-off on request
	initial begin
		int span;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_out = 1'b0;
			end else if (steady) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				span = 1 + pick_gap();
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (span) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no accepted item or config access
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IdleLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// RAM pattern fill holds off the input
		@(posedge clk);
		do @(posedge clk); while (in_stall);
		set_task_select(1'b0);

		// reset pattern, plain RAM, ROM space, I/O reads
		send_access(OpRead, 16'h0000, 8'h00);
		send_access(OpRead, 16'h0004, 8'hFF);
		send_access(OpWrite, 16'h1234, 8'hA5);
		send_access(OpRead, 16'h1234, 8'h00);
		send_access(OpRead, 16'h8000, 8'h00);
		send_access(OpWrite, 16'h9000, 8'h5A);
		send_access(OpRead, 16'hFF00, 8'h00);
		// page register write ignored with the MMU off
		send_access(OpWrite, 16'hFFA0, 8'h07);
		// MMU on with constant vectors
		send_access(OpWrite, MmuCtlAddr, 8'h48);
		send_access(OpWrite, 16'hFFA0, 8'hFF);
		send_access(OpWrite, 16'hFFA7, 8'h3C);
		send_access(OpWrite, 16'hFFA8, 8'h01);
		send_access(OpWrite, 16'hFFAF, 8'h80);
		// all-RAM on: vector page bypass, upper pages, wrapped page number
		send_access(OpWrite, 16'hFFDF, 8'h00);
		send_access(OpRead, 16'hFE10, 8'h00);
		send_access(OpWrite, 16'hFEFF, 8'h77);
		send_access(OpRead, 16'hC000, 8'h00);
		send_access(OpRead, 16'hE000, 8'h00);
		send_access(OpRead, 16'h0000, 8'h00);
		// constant vectors off: vector page goes through the MMU
		send_access(OpWrite, MmuCtlAddr, 8'h40);
		send_access(OpRead, 16'hFE10, 8'h00);
		// all-RAM off, then MMU off
		send_access(OpWrite, 16'hFFDE, 8'hFF);
		send_access(OpRead, 16'hA000, 8'h00);
		send_access(OpWrite, MmuCtlAddr, 8'h00);
		send_access(OpRead, 16'h0000, 8'h00);
		drain_replies();

		for (int phase = 0; phase < 6; phase++) begin
			set_task_select(phase % 2 == 0);
			steady = (phase == 2);
			// long receiver hold-off while the sender keeps offering
			if (phase == 3) hold_out = 1'b1;
			run_phase(PhaseItems);
			drain_replies();
		end

		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> paged_mmu_ram_bus.f
src/pmrb_pkg.sv
src/pmrb_queue.sv
src/pmrb_front.sv
src/pmrb_back.sv
src/paged_mmu_ram_bus.sv
tb/sv/pmrb_checker.sv
tb/sv/tb_paged_mmu_ram_bus.sv
